/* hdl/sme_pkg.sv */
// Shared types and constants of the subset mask enumerator.
`default_nettype none
package sme_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = 4;
  localparam int SIZE_W       = 5;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_N_USED   = 1'b0,
    REG_MAX_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_EMPTY,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic restart;
  } in_word_t;

  typedef struct packed {
    logic [MAX_ELEMENTS-1:0] subset_mask;
    logic [SIZE_W-1:0]       subset_size;
    logic                    last_row;
    logic                    exhausted;
  } out_word_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic out_free;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* hdl/sme_word_if.sv */
// Valid/ready channel carrying one word of a given payload type.
`default_nettype none
interface sme_word_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/sme_ctrl.sv */
// Controller: tracks the output register and issues the step command.
`default_nettype none
module sme_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sme_pkg::dp_cmd_t     cmd
);
  import sme_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.out_free = (state_r == ST_EMPTY) || out_ready;
    in_ready     = cmd.out_free;
    cmd.step     = in_valid && cmd.out_free;
    out_valid    = (state_r == ST_HOLD);
    state_nxt    = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (cmd.step) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !cmd.step) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/sme_dp.sv */
// Datapath: configuration, combination state, advance logic and output register.
`default_nettype none
module sme_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sme_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire sme_pkg::dp_cmd_t              cmd,
  input  wire sme_pkg::in_word_t             in_data,
  output sme_pkg::out_word_t                 out_data
);
  import sme_pkg::*;

  logic [CFG_W-1:0]  n_used_r, max_size_r;
  logic [IDX_W-1:0]  chosen_r   [MAX_ELEMENTS];
  logic [IDX_W-1:0]  chosen_nxt [MAX_ELEMENTS];
  logic [IDX_W-1:0]  cur_idx    [MAX_ELEMENTS];
  logic [SIZE_W-1:0] size_r, size_nxt, cur_size, k;
  logic              finished_r, finished_nxt, cur_fin;
  logic [SIZE_W-1:0] eff_n, eff_m;
  logic [MAX_ELEMENTS-1:0] lane_en, can_inc;
  logic              found;
  logic [IDX_W-1:0]  e_idx, base;
  logic signed [6:0] limit;
  out_word_t         out_r, out_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_used_r   <= CFG_W'(MAX_ELEMENTS);
      max_size_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_N_USED:   n_used_r   <= cfg_wdata;
        REG_MAX_SIZE: max_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (n_used_r == '0)                          eff_n = SIZE_W'(1);
    else if (n_used_r > CFG_W'(MAX_ELEMENTS))    eff_n = SIZE_W'(MAX_ELEMENTS);
    else                                         eff_n = n_used_r;
    if (max_size_r == '0)                        eff_m = SIZE_W'(1);
    else if (max_size_r > eff_n)                 eff_m = eff_n;
    else                                         eff_m = max_size_r;

    // A restart puts the enumeration back at the subset {0} first.
    cur_size = in_data.restart ? SIZE_W'(1) : size_r;
    cur_fin  = in_data.restart ? 1'b0 : finished_r;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cur_idx[i] = in_data.restart ? '0 : chosen_r[i];
    end
    k = (cur_size > SIZE_W'(MAX_ELEMENTS)) ? SIZE_W'(MAX_ELEMENTS) : cur_size;

    // Each lane checks whether its index still has room below its ceiling.
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      lane_en[i] = SIZE_W'(i) < k;
      limit      = $signed({2'b00, eff_n}) - $signed({2'b00, k}) + 7'(i);
      can_inc[i] = lane_en[i] && ($signed({3'b000, cur_idx[i]}) < limit);
    end

    // Priority find of the rightmost lane that can advance.
    found = 1'b0;
    e_idx = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (can_inc[i]) begin
        found = 1'b1;
        e_idx = IDX_W'(i);
      end
    end
    base = cur_idx[e_idx] + IDX_W'(1);

    out_nxt.subset_mask = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (lane_en[i]) out_nxt.subset_mask[cur_idx[i]] = 1'b1;
    end
    out_nxt.subset_size = k;
    out_nxt.last_row    = 1'b0;
    out_nxt.exhausted   = 1'b0;

    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      chosen_nxt[i] = cur_idx[i];
    end
    size_nxt     = cur_size;
    finished_nxt = cur_fin;

    priority if (cur_fin) begin
      out_nxt = '0;
      out_nxt.exhausted = 1'b1;
    end else if (found) begin
      // The advanced lane steps by one and every lane to its right follows on.
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        if (lane_en[i] && (IDX_W'(i) >= e_idx)) begin
          chosen_nxt[i] = base + (IDX_W'(i) - e_idx);
        end
      end
    end else if (k < eff_m) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        chosen_nxt[i] = (SIZE_W'(i) <= k) ? IDX_W'(i) : '0;
      end
      size_nxt = k + SIZE_W'(1);
    end else begin
      out_nxt.last_row = 1'b1;
      finished_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        chosen_r[i] <= '0;
      end
      size_r     <= SIZE_W'(1);
      finished_r <= 1'b0;
    end else if (cmd.step) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        chosen_r[i] <= chosen_nxt[i];
      end
      size_r     <= size_nxt;
      finished_r <= finished_nxt;
    end
  end

  // Output register: loaded on each step, which happens only while it is empty or its word is being taken.
  always_ff @(posedge clk) begin
    if (cmd.step && cmd.out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

/* hdl/subset_mask_enumerator_unit.sv */
// Top level of the subset mask enumerator: controller plus datapath.
`default_nettype none
// Channel   Direction  Word contents
// in_word   sink       restart
// out_word  source     subset_mask, subset_size, last_row, exhausted
// cfg_*     write      cfg_index selects n_used (0) or max_size (1)
//
// Each accepted input word yields exactly one output word, in the cycle after
// acceptance; unless the output stalls, a new word can be taken every cycle,
// as each advance is a combinational priority find over the sixteen index lanes.
// The output register is refilled in the same cycle that its word is taken,
// so a stall on the output only holds the input while the register is full.
// Reset is synchronous and active low; it needs no clearing pass, and leaves
// n_used at sixteen, max_size at one and the enumeration at the subset {0}.
module subset_mask_enumerator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sme_word_if.sink                           in_word,
  sme_word_if.source                         out_word,
  input  wire logic                          cfg_we,
  input  wire logic [sme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sme_pkg::CFG_W-1:0]     cfg_wdata
);
  import sme_pkg::*;

  dp_cmd_t   cmd;
  out_word_t dp_out;

  // The controller decides when a word moves; the datapath does the work.
  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .cmd       (cmd)
  );

  sme_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .in_data   (in_word.data),
    .out_data  (dp_out)
  );

  assign out_word.data = dp_out;

endmodule
`default_nettype wire
